// ----- hw/rtl/ptc_pkg.sv -----
// Shared types and constants for the pressure/temperature compensation pipeline.
`default_nettype none
package ptc_pkg;

   localparam int DATA_W    = 32;
   localparam int RAW_W     = 16;
   localparam int CSR_IDX_W = 3;
   localparam int SIDE_W    = 50;

   // CSR indexes
   localparam logic [CSR_IDX_W-1:0] REG_AC1_AC2 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_AC3_AC4 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_AC5_AC6 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_B1_B2   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MC_MD   = 3'd4;

   // Compensation constants
   localparam logic [DATA_W-1:0] TEMP_ROUND = 32'd8;
   localparam logic [DATA_W-1:0] B6_OFFSET  = 32'd4000;
   localparam logic [DATA_W-1:0] B3_ROUND   = 32'd2;
   localparam logic [DATA_W-1:0] X3_ROUND   = 32'd2;
   localparam logic [DATA_W-1:0] B4_BIAS    = 32'd32768;
   localparam logic [DATA_W-1:0] B7_SCALE   = 32'd50000;
   localparam logic [DATA_W-1:0] P_C1       = 32'd3038;
   localparam logic [DATA_W-1:0] P_C2       = 32'hFFFF_E343; // -7357
   localparam logic [DATA_W-1:0] P_C3       = 32'd3791;

   typedef logic [SIDE_W-1:0] side_type;

   // Calibration words, already extended to 32 bits
   typedef struct packed {
      logic [DATA_W-1:0] ac1;
      logic [DATA_W-1:0] ac2;
      logic [DATA_W-1:0] ac3;
      logic [DATA_W-1:0] ac4;
      logic [DATA_W-1:0] ac5;
      logic [DATA_W-1:0] ac6;
      logic [DATA_W-1:0] b1;
      logic [DATA_W-1:0] b2;
      logic [DATA_W-1:0] mc;
      logic [DATA_W-1:0] md;
   } cal_type;

   // Item handed to a divider
   typedef struct packed {
      logic              valid;
      logic [DATA_W-1:0] num;
      logic [DATA_W-1:0] den;
      side_type          side;
   } div_req_type;

   // Item leaving a divider
   typedef struct packed {
      logic              valid;
      logic [DATA_W-1:0] quo;
      side_type          side;
   } div_rsp_type;

   function automatic logic [DATA_W-1:0] asr(input logic [DATA_W-1:0] x,
                                              input int unsigned n);
      asr = DATA_W'($signed(x) >>> n);
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/ptc_udiv.sv -----
// Unsigned 32-bit restoring divider, one quotient bit per pipeline stage.
`default_nettype none
module ptc_udiv (
   input  wire                 clock,
   input  wire                 reset,
   input  ptc_pkg::div_req_type req,
   output ptc_pkg::div_rsp_type rsp
);

   localparam int W = ptc_pkg::DATA_W;

   logic                 valid_ff [0:W];
   logic [W-1:0]         num_ff   [0:W];
   logic [W-1:0]         den_ff   [0:W];
   logic [W-1:0]         rem_ff   [0:W];
   logic [W-1:0]         quo_ff   [0:W];
   ptc_pkg::side_type    side_ff  [0:W];

   // stage 0 just captures the request
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= req.valid;
      end
      num_ff[0]  <= req.num;
      den_ff[0]  <= req.den;
      rem_ff[0]  <= '0;
      quo_ff[0]  <= '0;
      side_ff[0] <= req.side;
   end

   for (genvar k = 0; k < W; k++) begin : g_stage
      logic [W:0]   shifted;
      logic [W:0]   trial;
      logic         take;
      logic [W-1:0] rem_in;

      always_comb begin
         shifted = {rem_ff[k], num_ff[k][W-1]};
         trial   = shifted - {1'b0, den_ff[k]};
         take    = ~trial[W];
         rem_in  = take ? trial[W-1:0] : shifted[W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else begin
            valid_ff[k+1] <= valid_ff[k];
         end
         num_ff[k+1]  <= {num_ff[k][W-2:0], 1'b0};
         den_ff[k+1]  <= den_ff[k];
         rem_ff[k+1]  <= rem_in;
         quo_ff[k+1]  <= {quo_ff[k][W-2:0], take};
         side_ff[k+1] <= side_ff[k];
      end
   end

   assign rsp.valid = valid_ff[W];
   assign rsp.quo   = quo_ff[W];
   assign rsp.side  = side_ff[W];

endmodule
`default_nettype wire

// ----- hw/rtl/ptc_pressure.sv -----
// Pressure front end: B5..B7 and B4 between the two divider pipelines.
`default_nettype none
module ptc_pressure (
   input  wire                  clock,
   input  wire                  reset,
   input  ptc_pkg::cal_type     cal,
   input  ptc_pkg::div_rsp_type tdiv,
   output ptc_pkg::div_req_type pdiv
);

   localparam int W = ptc_pkg::DATA_W;
   localparam int R = ptc_pkg::RAW_W;

   // side from the temperature divider: {fault, neg, up, x1}
   logic [W-1:0] s_x1;
   logic [R-1:0] s_up;
   logic         s_neg;
   logic         s_fault;
   assign s_x1    = tdiv.side[W-1:0];
   assign s_up    = tdiv.side[W+R-1:W];
   assign s_neg   = tdiv.side[W+R];
   assign s_fault = tdiv.side[W+R+1];

   logic [6:0] v_ff;

   // stage 0
   logic [W-1:0] x2_0, b5_0;
   logic [W-1:0] temp0_ff, b6_0_ff;
   logic [R-1:0] up0_ff;
   logic         f0_ff;
   always_comb begin
      x2_0 = s_neg ? (W'(0) - tdiv.quo) : tdiv.quo;
      b5_0 = s_x1 + x2_0;
   end

   // stage 1
   logic [W-1:0] sqp_ff, ac2p_ff, ac3p_ff, temp1_ff;
   logic [R-1:0] up1_ff;
   logic         f1_ff;

   // stage 2
   logic [W-1:0] sq_ff, xa2_ff, xc2_ff, temp2_ff;
   logic [R-1:0] up2_ff;
   logic         f2_ff;

   // stage 3
   logic [W-1:0] b2p_ff, b1p_ff, xa3_ff, xc3_ff, temp3_ff;
   logic [R-1:0] up3_ff;
   logic         f3_ff;

   // stage 4
   logic [W-1:0] b3v, b3_in, x3b_in;
   logic [W-1:0] b3_ff, x3b_ff, temp4_ff;
   logic [R-1:0] up4_ff;
   logic         f4_ff;
   always_comb begin
      b3v    = (cal.ac1 << 2) + ptc_pkg::asr(b2p_ff, 11) + xa3_ff + ptc_pkg::B3_ROUND;
      // signed divide by 4, truncating toward zero
      b3_in  = ptc_pkg::asr(b3v + (b3v[W-1] ? W'(3) : W'(0)), 2);
      x3b_in = ptc_pkg::asr(xc3_ff + ptc_pkg::asr(b1p_ff, 16) + ptc_pkg::X3_ROUND, 2);
   end

   // stage 5
   logic [W-1:0] b4prod;
   logic [W-1:0] b4_ff, diff_ff, temp5_ff;
   logic         f5_ff;
   assign b4prod = cal.ac4 * (x3b_ff + ptc_pkg::B4_BIAS);

   // stage 6
   logic [W-1:0] b7;
   assign b7 = diff_ff * ptc_pkg::B7_SCALE;

   logic              pv_ff;
   logic [W-1:0]      pnum_ff, pden_ff;
   ptc_pkg::side_type pside_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff  <= '0;
         pv_ff <= 1'b0;
      end else begin
         v_ff  <= {v_ff[5:0], tdiv.valid};
         pv_ff <= v_ff[5];
      end
      // 0
      temp0_ff <= ptc_pkg::asr(b5_0 + ptc_pkg::TEMP_ROUND, 4);
      b6_0_ff  <= b5_0 - ptc_pkg::B6_OFFSET;
      up0_ff   <= s_up;
      f0_ff    <= s_fault;
      // 1
      sqp_ff   <= b6_0_ff * b6_0_ff;
      ac2p_ff  <= cal.ac2 * b6_0_ff;
      ac3p_ff  <= cal.ac3 * b6_0_ff;
      temp1_ff <= temp0_ff;
      up1_ff   <= up0_ff;
      f1_ff    <= f0_ff;
      // 2
      sq_ff    <= ptc_pkg::asr(sqp_ff, 12);
      xa2_ff   <= ptc_pkg::asr(ac2p_ff, 11);
      xc2_ff   <= ptc_pkg::asr(ac3p_ff, 13);
      temp2_ff <= temp1_ff;
      up2_ff   <= up1_ff;
      f2_ff    <= f1_ff;
      // 3
      b2p_ff   <= cal.b2 * sq_ff;
      b1p_ff   <= cal.b1 * sq_ff;
      xa3_ff   <= xa2_ff;
      xc3_ff   <= xc2_ff;
      temp3_ff <= temp2_ff;
      up3_ff   <= up2_ff;
      f3_ff    <= f2_ff;
      // 4
      b3_ff    <= b3_in;
      x3b_ff   <= x3b_in;
      temp4_ff <= temp3_ff;
      up4_ff   <= up3_ff;
      f4_ff    <= f3_ff;
      // 5
      b4_ff    <= {15'd0, b4prod[W-1:15]};
      diff_ff  <= {{(W-R){1'b0}}, up4_ff} - b3_ff;
      temp5_ff <= temp4_ff;
      f5_ff    <= f4_ff;
      // 6: B7 with bit 31 set divides first, doubles after
      pnum_ff  <= b7[W-1] ? b7 : {b7[W-2:0], 1'b0};
      pden_ff  <= b4_ff;
      pside_ff <= {{(ptc_pkg::SIDE_W-W-2){1'b0}}, f5_ff | (b4_ff == '0), b7[W-1], temp5_ff};
   end

   assign pdiv.valid = pv_ff;
   assign pdiv.num   = pnum_ff;
   assign pdiv.den   = pden_ff;
   assign pdiv.side  = pside_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/ptc_poly.sv -----
// Final pressure correction polynomial and result registers.
`default_nettype none
module ptc_poly (
   input  wire                  clock,
   input  wire                  reset,
   input  ptc_pkg::div_rsp_type pdiv,
   output logic                 rsp_valid,
   output logic signed [31:0]   rsp_temperature_tenths,
   output logic signed [31:0]   rsp_pressure_pa,
   output logic                 rsp_divide_fault
);

   localparam int W = ptc_pkg::DATA_W;

   logic [W-1:0] s_temp;
   logic         s_late, s_fault;
   assign s_temp  = pdiv.side[W-1:0];
   assign s_late  = pdiv.side[W];
   assign s_fault = pdiv.side[W+1];

   logic [2:0]   v_ff;
   logic [W-1:0] p0_ff, t0_ff;
   logic         f0_ff;
   logic [W-1:0] a1_ff, b1_ff, p1_ff, t1_ff;
   logic         f1_ff;
   logic [W-1:0] c2_ff, bs2_ff, p2_ff, t2_ff;
   logic         f2_ff;
   logic [W-1:0] pa, pfin;

   logic              rv_ff, rf_ff;
   logic [W-1:0]      rt_ff, rp_ff;

   always_comb begin
      pa   = ptc_pkg::asr(p0_ff, 8);
      pfin = p2_ff + ptc_pkg::asr(ptc_pkg::asr(c2_ff, 16) + bs2_ff + ptc_pkg::P_C3, 4);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff  <= '0;
         rv_ff <= 1'b0;
      end else begin
         v_ff  <= {v_ff[1:0], pdiv.valid};
         rv_ff <= v_ff[2];
      end
      p0_ff  <= s_late ? {pdiv.quo[W-2:0], 1'b0} : pdiv.quo;
      t0_ff  <= s_temp;
      f0_ff  <= s_fault;
      a1_ff  <= pa * pa;
      b1_ff  <= ptc_pkg::P_C2 * p0_ff;
      p1_ff  <= p0_ff;
      t1_ff  <= t0_ff;
      f1_ff  <= f0_ff;
      c2_ff  <= a1_ff * ptc_pkg::P_C1;
      bs2_ff <= ptc_pkg::asr(b1_ff, 16);
      p2_ff  <= p1_ff;
      t2_ff  <= t1_ff;
      f2_ff  <= f1_ff;
      rt_ff  <= f2_ff ? '0 : t2_ff;
      rp_ff  <= f2_ff ? '0 : pfin;
      rf_ff  <= f2_ff;
   end

   assign rsp_valid              = rv_ff;
   assign rsp_temperature_tenths = $signed(rt_ff);
   assign rsp_pressure_pa        = $signed(rp_ff);
   assign rsp_divide_fault       = rf_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/pressure_temperature_compensation.sv -----
// Top level: calibration CSRs, temperature front end and the two divider pipelines.
//
//   channel  ports                               handshake
//   -------  ----------------------------------  ------------------------------
//   request  req_raw_temperature, req_raw_pressure  start & !busy (busy is always 0)
//   result   rsp_temperature_tenths, rsp_pressure_pa, rsp_divide_fault  rsp_valid strobe
//   csr      csr_index, csr_data                 csr_valid & csr_ready (ready always 1)
//
// One item enters per cycle. Latency is set by the two 32-stage dividers (one
// quotient bit per stage) plus the multiply stages around them. Reset (synchronous)
// clears valid bits and the calibration registers. The receiver cannot stall, so
// the pipeline never holds.
`default_nettype none
module pressure_temperature_compensation (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  wire         [15:0] req_raw_temperature,
   input  wire         [15:0] req_raw_pressure,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_temperature_tenths,
   output logic signed [31:0] rsp_pressure_pa,
   output logic               rsp_divide_fault,
   input  wire                csr_valid,
   output logic               csr_ready,
   input  wire          [2:0] csr_index,
   input  wire         [31:0] csr_data
);

   localparam int W = ptc_pkg::DATA_W;
   localparam int R = ptc_pkg::RAW_W;

   // calibration registers
   logic [W-1:0] ac1_ac2_ff, ac3_ac4_ff, ac5_ac6_ff, b1_b2_ff, mc_md_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ac1_ac2_ff <= '0;
         ac3_ac4_ff <= '0;
         ac5_ac6_ff <= '0;
         b1_b2_ff   <= '0;
         mc_md_ff   <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            ptc_pkg::REG_AC1_AC2: ac1_ac2_ff <= csr_data;
            ptc_pkg::REG_AC3_AC4: ac3_ac4_ff <= csr_data;
            ptc_pkg::REG_AC5_AC6: ac5_ac6_ff <= csr_data;
            ptc_pkg::REG_B1_B2:   b1_b2_ff   <= csr_data;
            ptc_pkg::REG_MC_MD:   mc_md_ff   <= csr_data;
            default: ;  // out-of-range writes are dropped
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   ptc_pkg::cal_type cal;
   always_comb begin
      cal.ac1 = {{(W-R){ac1_ac2_ff[31]}}, ac1_ac2_ff[31:16]};
      cal.ac2 = {{(W-R){ac1_ac2_ff[15]}}, ac1_ac2_ff[15:0]};
      cal.ac3 = {{(W-R){ac3_ac4_ff[31]}}, ac3_ac4_ff[31:16]};
      cal.ac4 = {{(W-R){1'b0}},          ac3_ac4_ff[15:0]};
      cal.ac5 = {{(W-R){1'b0}},          ac5_ac6_ff[31:16]};
      cal.ac6 = {{(W-R){1'b0}},          ac5_ac6_ff[15:0]};
      cal.b1  = {{(W-R){b1_b2_ff[31]}},   b1_b2_ff[31:16]};
      cal.b2  = {{(W-R){b1_b2_ff[15]}},   b1_b2_ff[15:0]};
      cal.mc  = {{(W-R){mc_md_ff[31]}},   mc_md_ff[31:16]};
      cal.md  = {{(W-R){mc_md_ff[15]}},   mc_md_ff[15:0]};
   end

   // stage A: (UT - AC6) * AC5
   logic         a_v_ff;
   logic [W-1:0] a_prod_ff;
   logic [R-1:0] a_up_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else begin
         a_v_ff <= start & ~busy;
      end
      a_prod_ff <= ({{(W-R){1'b0}}, req_raw_temperature} - cal.ac6) * cal.ac5;
      a_up_ff   <= req_raw_pressure;
   end

   // X1, divisor X1 + MD, magnitudes for the unsigned divider
   logic [W-1:0] x1, tden, tnum, mnum, mden;
   logic         tneg, tzero;
   ptc_pkg::div_req_type treq;
   ptc_pkg::div_rsp_type trsp;
   ptc_pkg::div_req_type preq;
   ptc_pkg::div_rsp_type prsp;

   always_comb begin
      x1    = ptc_pkg::asr(a_prod_ff, 15);
      tden  = x1 + cal.md;
      tnum  = cal.mc << 11;
      tzero = (tden == '0);
      tneg  = tnum[W-1] ^ tden[W-1];
      mnum  = tnum[W-1] ? (W'(0) - tnum) : tnum;
      mden  = tden[W-1] ? (W'(0) - tden) : tden;
      treq.valid = a_v_ff;
      treq.num   = mnum;
      treq.den   = mden;
      treq.side  = {tzero, tneg, a_up_ff, x1};
   end

   ptc_udiv u_tdiv (
      .clock (clock),
      .reset (reset),
      .req   (treq),
      .rsp   (trsp)
   );

   ptc_pressure u_pressure (
      .clock (clock),
      .reset (reset),
      .cal   (cal),
      .tdiv  (trsp),
      .pdiv  (preq)
   );

   ptc_udiv u_pdiv (
      .clock (clock),
      .reset (reset),
      .req   (preq),
      .rsp   (prsp)
   );

   ptc_poly u_poly (
      .clock                  (clock),
      .reset                  (reset),
      .pdiv                   (prsp),
      .rsp_valid              (rsp_valid),
      .rsp_temperature_tenths (rsp_temperature_tenths),
      .rsp_pressure_pa        (rsp_pressure_pa),
      .rsp_divide_fault       (rsp_divide_fault)
   );

endmodule
`default_nettype wire
